### design/rau_pkg.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Mode codes, microcode control word layout and the microcode program.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam logic [2:0] MODE_ADD  = 3'd0;
  localparam logic [2:0] MODE_SUB  = 3'd1;
  localparam logic [2:0] MODE_MUL  = 3'd2;
  localparam logic [2:0] MODE_DIV  = 3'd3;
  localparam logic [2:0] MODE_LESS = 3'd4;
  localparam logic [2:0] MODE_NEG  = 3'd5;

  localparam int PC_W = 5;
  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [2:0] {
    MS_NONE,
    MS_AN_BD,
    MS_AD_BN,
    MS_AN_BN,
    MS_AD_BD
  } mul_sel_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_N_LD_P,
    OP_N_ADD_P,
    OP_N_SUB_P,
    OP_D_LD_P,
    OP_NEG_A,
    OP_SIGN_FIX,
    OP_RED_INIT,
    OP_GCD_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_EMIT_RES,
    OP_EMIT_LESS,
    OP_EMIT_ERR,
    OP_EMIT_ZERO
  } op_t;

  typedef enum logic [2:0] {
    JC_NONE,
    JC_ALWAYS,
    JC_BN_ZERO,
    JC_SKIP_RED,
    JC_GCD_BUSY,
    JC_DIV_BUSY
  } jc_t;

  typedef struct packed {
    mul_sel_t mul;
    op_t      op;
    jc_t      jc;
    pc_t      target;
  } ctrl_t;

  typedef struct packed {
    logic bn_zero;
    logic skip_red;
    logic gcd_busy;
    logic div_busy;
  } flags_t;

  typedef struct packed {
    logic idle;
    logic emit;
    op_t  kind;
  } seq_stat_t;

  localparam pc_t PC_ADD      = 5'd0;
  localparam pc_t PC_SUB      = 5'd4;
  localparam pc_t PC_MUL      = 5'd8;
  localparam pc_t PC_DIV      = 5'd11;
  localparam pc_t PC_LESS     = 5'd15;
  localparam pc_t PC_NEG      = 5'd19;
  localparam pc_t PC_ERR      = 5'd20;
  localparam pc_t PC_ZERO     = 5'd21;
  localparam pc_t PC_RED      = 5'd22;
  localparam pc_t PC_GCD      = 5'd23;
  localparam pc_t PC_DIV_LOOP = 5'd25;
  localparam pc_t PC_EMIT     = 5'd26;

  function automatic ctrl_t cw(input mul_sel_t mul, input op_t op, input jc_t jc,
                               input pc_t target);
    ctrl_t c;
    c.mul    = mul;
    c.op     = op;
    c.jc     = jc;
    c.target = target;
    return c;
  endfunction

  function automatic pc_t entry(input logic [2:0] mode);
    pc_t p;
    case (mode)
      MODE_ADD:  p = PC_ADD;
      MODE_SUB:  p = PC_SUB;
      MODE_MUL:  p = PC_MUL;
      MODE_DIV:  p = PC_DIV;
      MODE_LESS: p = PC_LESS;
      MODE_NEG:  p = PC_NEG;
      default:   p = PC_ZERO;
    endcase
    return p;
  endfunction

  function automatic ctrl_t rom(input pc_t addr);
    ctrl_t c;
    case (addr)
      5'd0:    c = cw(MS_AN_BD, OP_NOP,       JC_NONE,     PC_ADD);
      5'd1:    c = cw(MS_AD_BN, OP_N_LD_P,    JC_NONE,     PC_ADD);
      5'd2:    c = cw(MS_AD_BD, OP_N_ADD_P,   JC_NONE,     PC_ADD);
      5'd3:    c = cw(MS_NONE,  OP_D_LD_P,    JC_ALWAYS,   PC_RED);
      5'd4:    c = cw(MS_AN_BD, OP_NOP,       JC_NONE,     PC_ADD);
      5'd5:    c = cw(MS_AD_BN, OP_N_LD_P,    JC_NONE,     PC_ADD);
      5'd6:    c = cw(MS_AD_BD, OP_N_SUB_P,   JC_NONE,     PC_ADD);
      5'd7:    c = cw(MS_NONE,  OP_D_LD_P,    JC_ALWAYS,   PC_RED);
      5'd8:    c = cw(MS_AN_BN, OP_NOP,       JC_NONE,     PC_ADD);
      5'd9:    c = cw(MS_AD_BD, OP_N_LD_P,    JC_NONE,     PC_ADD);
      5'd10:   c = cw(MS_NONE,  OP_D_LD_P,    JC_ALWAYS,   PC_RED);
      5'd11:   c = cw(MS_AN_BD, OP_NOP,       JC_BN_ZERO,  PC_ERR);
      5'd12:   c = cw(MS_AD_BN, OP_N_LD_P,    JC_NONE,     PC_ADD);
      5'd13:   c = cw(MS_NONE,  OP_D_LD_P,    JC_NONE,     PC_ADD);
      5'd14:   c = cw(MS_NONE,  OP_SIGN_FIX,  JC_ALWAYS,   PC_RED);
      5'd15:   c = cw(MS_AN_BD, OP_NOP,       JC_NONE,     PC_ADD);
      5'd16:   c = cw(MS_AD_BN, OP_N_LD_P,    JC_NONE,     PC_ADD);
      5'd17:   c = cw(MS_NONE,  OP_D_LD_P,    JC_NONE,     PC_ADD);
      5'd18:   c = cw(MS_NONE,  OP_EMIT_LESS, JC_NONE,     PC_ADD);
      5'd19:   c = cw(MS_NONE,  OP_NEG_A,     JC_ALWAYS,   PC_RED);
      5'd20:   c = cw(MS_NONE,  OP_EMIT_ERR,  JC_NONE,     PC_ADD);
      5'd21:   c = cw(MS_NONE,  OP_EMIT_ZERO, JC_NONE,     PC_ADD);
      5'd22:   c = cw(MS_NONE,  OP_RED_INIT,  JC_SKIP_RED, PC_EMIT);
      5'd23:   c = cw(MS_NONE,  OP_GCD_STEP,  JC_GCD_BUSY, PC_GCD);
      5'd24:   c = cw(MS_NONE,  OP_DIV_INIT,  JC_NONE,     PC_ADD);
      5'd25:   c = cw(MS_NONE,  OP_DIV_STEP,  JC_DIV_BUSY, PC_DIV_LOOP);
      5'd26:   c = cw(MS_NONE,  OP_EMIT_RES,  JC_NONE,     PC_ADD);
      default: c = cw(MS_NONE,  OP_EMIT_ZERO, JC_NONE,     PC_ADD);
    endcase
    return c;
  endfunction

endpackage

### design/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Adds, subtracts, multiplies or divides two fractions, or negates the first, and
// returns the result reduced by its greatest common divisor; compare gives is_less.
// ----------------------------------------------------------------------------
// From the accepting edge the fraction is formed with the multiplier; a zero
// numerator or denominator goes straight to the result, else binary GCD steps run
// until one operand is zero and DW divide steps, DW = 2*OPERAND_WIDTH+1 capped at
// 64, divide both by the GCD. Compare, divide by zero and unused modes skip these.
// One item at a time: the next item is taken once the sequencer is idle again after
// the result is registered. Synchronous reset clears the sequencer and output valid.
module rational_arithmetic_unit #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // a_num, a_den, b_num, b_den from the lowest bit up, zero padded
  input  logic [((4*OPERAND_WIDTH-2+7)/8)*8-1:0] s_tdata,
  // mode
  input  logic [2:0]                 s_tuser,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // res_num, res_den, is_less from the lowest bit up
  output logic [63:0]                m_tdata,
  // div_error
  output logic                       m_tuser
);

  localparam int W = OPERAND_WIDTH;

  logic               start;
  logic               out_free;
  rau_pkg::ctrl_t     ctrl;
  rau_pkg::flags_t    flags;
  rau_pkg::seq_stat_t stat;
  logic [31:0]        dp_num;
  logic [30:0]        dp_den;
  logic               dp_less;
  logic [31:0]        out_num;
  logic [30:0]        out_den;
  logic               out_less;
  logic               out_err;

  assign s_tready = stat.idle && !rst;
  assign start    = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  rau_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .mode     (s_tuser),
    .out_free (out_free),
    .flags    (flags),
    .ctrl     (ctrl),
    .stat     (stat)
  );

  rau_dp #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dp (
    .clk     (clk),
    .load    (start),
    .a_num   (s_tdata[W-1:0]),
    .a_den   (s_tdata[2*W-2:W]),
    .b_num   (s_tdata[3*W-2:2*W-1]),
    .b_den   (s_tdata[4*W-3:3*W-1]),
    .ctrl    (ctrl),
    .flags   (flags),
    .res_num (dp_num),
    .res_den (dp_den),
    .less    (dp_less)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (stat.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.emit) begin
      case (stat.kind)
        rau_pkg::OP_EMIT_RES: begin
          out_num  <= dp_num;
          out_den  <= dp_den;
          out_less <= 1'b0;
          out_err  <= 1'b0;
        end
        rau_pkg::OP_EMIT_LESS: begin
          out_num  <= '0;
          out_den  <= '0;
          out_less <= dp_less;
          out_err  <= 1'b0;
        end
        rau_pkg::OP_EMIT_ERR: begin
          out_num  <= '0;
          out_den  <= '0;
          out_less <= 1'b0;
          out_err  <= 1'b1;
        end
        default: begin
          out_num  <= '0;
          out_den  <= '0;
          out_less <= 1'b0;
          out_err  <= 1'b0;
        end
      endcase
    end
  end

  assign m_tdata = {out_less, out_den, out_num};
  assign m_tuser = out_err;

endmodule

### design/rau_dp.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit datapath
// Shared multiplier, numerator and denominator registers, binary GCD unit and
// a pair of bit-serial dividers, all driven by the microcode control word.
// ----------------------------------------------------------------------------
module rau_dp #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      load,
  input  logic [OPERAND_WIDTH-1:0]  a_num,
  input  logic [OPERAND_WIDTH-2:0]  a_den,
  input  logic [OPERAND_WIDTH-1:0]  b_num,
  input  logic [OPERAND_WIDTH-2:0]  b_den,
  input  rau_pkg::ctrl_t            ctrl,
  output rau_pkg::flags_t           flags,
  output logic [31:0]               res_num,
  output logic [30:0]               res_den,
  output logic                      less
);

  localparam int W  = OPERAND_WIDTH;
  localparam int DW = (2 * W + 1 > 64) ? 64 : 2 * W + 1;
  localparam int PW = 2 * W + 2;
  localparam int CW = $clog2(DW);

  logic signed [W-1:0] an;
  logic        [W-2:0] ad;
  logic signed [W-1:0] bn;
  logic        [W-2:0] bd;
  logic        [DW-1:0] p;
  logic        [DW-1:0] n;
  logic        [DW-1:0] d;
  logic                 neg;
  logic        [DW-1:0] u;
  logic        [DW-1:0] v;
  logic        [DW-1:0] g;
  logic        [DW-1:0] rn;
  logic        [DW-1:0] rd;
  logic        [CW-1:0] cnt;

  logic signed [PW-1:0] ma;
  logic signed [PW-1:0] mb;
  logic signed [PW-1:0] prod;
  logic        [DW:0]   uv_diff;
  logic        [DW:0]   sn;
  logic        [DW:0]   sd;
  logic        [DW+1:0] dn;
  logic        [DW+1:0] dd;
  logic                 gen;
  logic                 ged;
  logic        [DW-1:0] n_abs;
  logic        [DW-1:0] sv;
  logic        [63:0]   sv_ext;
  logic        [63:0]   d_ext;

  always_comb begin
    case (ctrl.mul)
      rau_pkg::MS_AN_BD: begin
        ma = PW'(an);
        mb = PW'({1'b0, bd});
      end
      rau_pkg::MS_AD_BN: begin
        ma = PW'({1'b0, ad});
        mb = PW'(bn);
      end
      rau_pkg::MS_AN_BN: begin
        ma = PW'(an);
        mb = PW'(bn);
      end
      rau_pkg::MS_AD_BD: begin
        ma = PW'({1'b0, ad});
        mb = PW'({1'b0, bd});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    prod = ma * mb;
  end

  always_comb begin
    uv_diff = {1'b0, u} - {1'b0, v};
    sn      = {rn, n[DW-1]};
    sd      = {rd, d[DW-1]};
    dn      = {1'b0, sn} - {2'b00, g};
    dd      = {1'b0, sd} - {2'b00, g};
    gen     = !dn[DW+1];
    ged     = !dd[DW+1];
    n_abs   = n[DW-1] ? ('0 - n) : n;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      an <= a_num;
      ad <= a_den;
      bn <= b_num;
      bd <= b_den;
    end
    if (ctrl.mul != rau_pkg::MS_NONE) begin
      p <= prod[DW-1:0];
    end
    case (ctrl.op)
      rau_pkg::OP_N_LD_P:  n <= p;
      rau_pkg::OP_N_ADD_P: n <= n + p;
      rau_pkg::OP_N_SUB_P: n <= n - p;
      rau_pkg::OP_D_LD_P:  d <= p;
      rau_pkg::OP_NEG_A: begin
        n <= '0 - DW'(an);
        d <= DW'(ad);
      end
      rau_pkg::OP_SIGN_FIX: begin
        if (d[DW-1]) begin
          n <= '0 - n;
          d <= '0 - d;
        end
      end
      rau_pkg::OP_RED_INIT: begin
        neg <= n[DW-1];
        n   <= n_abs;
        u   <= n_abs;
        v   <= d;
      end
      rau_pkg::OP_GCD_STEP: begin
        if (u != '0 && v != '0) begin
          if (!u[0] && !v[0]) begin
            u <= u >> 1;
            v <= v >> 1;
            n <= n >> 1;
            d <= d >> 1;
          end else if (!u[0]) begin
            u <= u >> 1;
          end else if (!v[0]) begin
            v <= v >> 1;
          end else if (!uv_diff[DW]) begin
            u <= uv_diff[DW-1:0];
          end else begin
            v <= v - u;
          end
        end
      end
      rau_pkg::OP_DIV_INIT: begin
        g   <= u | v;
        rn  <= '0;
        rd  <= '0;
        cnt <= '0;
      end
      rau_pkg::OP_DIV_STEP: begin
        n   <= {n[DW-2:0], gen};
        d   <= {d[DW-2:0], ged};
        rn  <= gen ? dn[DW-1:0] : sn[DW-1:0];
        rd  <= ged ? dd[DW-1:0] : sd[DW-1:0];
        cnt <= cnt + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    flags.bn_zero  = (bn == '0);
    flags.skip_red = (n == '0) || (d == '0);
    flags.gcd_busy = (u != '0) && (v != '0);
    flags.div_busy = (cnt != CW'(DW - 1));
    sv      = neg ? ('0 - n) : n;
    sv_ext  = 64'($signed(sv));
    d_ext   = 64'(d);
    res_num = sv_ext[31:0];
    res_den = d_ext[30:0];
    less    = $signed(n) < $signed(d);
  end

endmodule

### design/rau_seq.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit sequencer
// Step counter over the microcode program, with mode dispatch, conditional
// jumps and a hold on the result step while the output register is full.
// ----------------------------------------------------------------------------
module rau_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [2:0]         mode,
  input  logic               out_free,
  input  rau_pkg::flags_t    flags,
  output rau_pkg::ctrl_t     ctrl,
  output rau_pkg::seq_stat_t stat
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t         state;
  state_t         state_next;
  rau_pkg::pc_t   pc;
  rau_pkg::pc_t   pc_next;
  rau_pkg::ctrl_t cw;
  logic           is_emit;
  logic           stall;
  logic           taken;

  always_comb begin
    cw      = rau_pkg::rom(pc);
    is_emit = cw.op inside {rau_pkg::OP_EMIT_RES, rau_pkg::OP_EMIT_LESS,
                            rau_pkg::OP_EMIT_ERR, rau_pkg::OP_EMIT_ZERO};
    stall   = is_emit && !out_free;
    case (cw.jc)
      rau_pkg::JC_ALWAYS:   taken = 1'b1;
      rau_pkg::JC_BN_ZERO:  taken = flags.bn_zero;
      rau_pkg::JC_SKIP_RED: taken = flags.skip_red;
      rau_pkg::JC_GCD_BUSY: taken = flags.gcd_busy;
      rau_pkg::JC_DIV_BUSY: taken = flags.div_busy;
      default:              taken = 1'b0;
    endcase

    ctrl = cw;
    if (state != ST_RUN || stall) begin
      ctrl.mul = rau_pkg::MS_NONE;
      ctrl.op  = rau_pkg::OP_NOP;
    end

    stat.idle = (state == ST_IDLE);
    stat.emit = (state == ST_RUN) && is_emit && out_free;
    stat.kind = cw.op;

    state_next = state;
    pc_next    = pc;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_RUN;
          pc_next    = rau_pkg::entry(mode);
        end
      end
      ST_RUN: begin
        if (is_emit) begin
          if (out_free) begin
            state_next = ST_IDLE;
          end
        end else begin
          pc_next = taken ? cw.target : pc + 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pc    <= rau_pkg::PC_ADD;
    end else begin
      state <= state_next;
      pc    <= pc_next;
    end
  end

endmodule

### design/rau_checker.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit checker
// Port-level checks on reset, one item at a time, the result flag encodings and a stalled output holding steady.
// ----------------------------------------------------------------------------
module rau_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tuser
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("Output valid survived reset.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (!rst && s_tvalid && s_tready) |=> !s_tready)
    else $error("A second item was taken while one is in flight.");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == 64'd0))
    else $error("Divide error item carries a nonzero fraction.");

  a_less_only: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[63]) |-> (m_tdata[62:0] == 63'd0 && !m_tuser))
    else $error("Compare item carries a fraction or an error.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("Stalled output item changed.");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
